// ----- sv/epad_pkg.sv -----
// Shared constants, types and helpers for the edge replication padder.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package epad_pkg;

  localparam int MAX_PAD      = 7;
  localparam int MAX_DIM      = 4096;
  localparam int SAMPLE_BITS  = 16;
  localparam int RESULT_LIMIT = 64;

  localparam int DIM_W   = 13;  // frame size registers
  localparam int PAD_W   = 3;   // pad registers
  localparam int PITCH_W = 14;  // row pitch register
  localparam int POS_W   = 12;  // source position counters
  localparam int CRD_W   = 13;  // destination row or column
  localparam int ADDR_W  = 26;  // linear destination address
  localparam int CNT_W   = $clog2(RESULT_LIMIT);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  typedef logic [DIM_W-1:0]       dim_t;
  typedef logic [PAD_W-1:0]       pad_t;
  typedef logic [PITCH_W-1:0]     pitch_t;
  typedef logic [POS_W-1:0]       pos_t;
  typedef logic [CRD_W-1:0]       crd_t;
  typedef logic [ADDR_W-1:0]      addr_t;
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [CFG_IDX_W-1:0]   cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]  cfg_data_t;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 3'd0,
    CFG_FRAME_HEIGHT = 3'd1,
    CFG_PAD_COLUMNS  = 3'd2,
    CFG_PAD_ROWS     = 3'd3,
    CFG_ROW_PITCH    = 3'd4
  } cfg_reg_t;

  // inclusive range of destination positions along one axis
  typedef struct packed {
    crd_t first;
    crd_t last;
  } span_t;

  // zero size acts as one, oversize acts as the largest plane
  function automatic dim_t clamp_dim(input dim_t v);
    dim_t r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic pad_t clamp_pad(input pad_t v);
    pad_t r;
    if (v > PAD_W'(MAX_PAD)) begin
      r = PAD_W'(MAX_PAD);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- sv/epad_pix_if.sv -----
// Input channel of the padder: one source sample per item.
// Depends on epad_pkg for the sample type.
`default_nettype none

interface epad_pix_if;
  import epad_pkg::*;

  logic    valid;
  logic    ready;
  sample_t pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink   (input valid, input pixel_value, output ready);
endinterface

`default_nettype wire

// ----- sv/epad_wr_if.sv -----
// Result channel of the padder: one buffer write per item.
// Depends on epad_pkg for the address and sample types.
`default_nettype none

interface epad_wr_if;
  import epad_pkg::*;

  logic    valid;
  logic    ready;
  addr_t   dest_address;
  sample_t sample_out;
  logic    last_write;

  modport source (output valid, output dest_address, output sample_out,
                  output last_write, input ready);
  modport sink   (input valid, input dest_address, input sample_out,
                  input last_write, output ready);
endinterface

`default_nettype wire

// ----- sv/epad_axis.sv -----
// Destination range along one axis for one source position: the offset
// position, widened to the pad on the first or last position of the axis.
// Depends on epad_pkg.
`default_nettype none

module epad_axis (
  input  epad_pkg::pos_t  pos,
  input  epad_pkg::dim_t  size,
  input  epad_pkg::pad_t  pad,
  output epad_pkg::span_t span
);
  import epad_pkg::*;

  logic at_first;
  logic at_last;
  crd_t centre;

  // edge detection and offset position
  assign at_first = (pos == '0);
  assign at_last  = ({1'b0, pos} == (size - DIM_W'(1)));
  assign centre   = {1'b0, pos} + CRD_W'(pad);

  // the pad positions are contiguous with the offset position
  assign span.first = at_first ? '0 : centre;
  assign span.last  = at_last ? (CRD_W'(size) + CRD_W'({pad, 1'b0}) - CRD_W'(1))
                              : centre;
endmodule

`default_nettype wire

// ----- sv/edge_replication_padder.sv -----
// Top level of the edge replication padder: sequencer, address unit and
// frame position counters. Depends on epad_pkg, epad_pix_if, epad_wr_if
// and epad_axis.
//
// Usage: samples of an unpadded plane enter in raster order on in_pix.
// Each sample leaves as one or more buffer writes on out_wr: its own
// write at the offset position, plus replicas into the pad columns, pad
// rows and corner blocks when it lies on an edge. Writes of one sample
// come in ascending destination row, then column; the final one carries
// last_write. At most 64 writes are made per sample.
// Timing: after the accepting edge, the S_MUL state does the row base
// multiply and the S_LOAD state forms the first address, so the first
// write is offered in S_EMIT; then one write per cycle while out_wr is
// ready. in_pix is ready again the cycle after the final write.
// A stall on out_wr holds the current write and its address steady.
// Reset (rst_n low, synchronous) loads the register defaults (1x1 plane,
// no pad, pitch 1) and returns the position counters to the frame start.
// Configuration writes are taken at any cycle with cfg_we high; change
// them only while no sample is in work.
`default_nettype none

module edge_replication_padder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  epad_pkg::cfg_idx_t  cfg_index,
  input  epad_pkg::cfg_data_t cfg_data,
  epad_pix_if.sink            in_pix,
  epad_wr_if.source           out_wr
);
  import epad_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_LOAD,
    S_EMIT
  } state_t;

  // configuration registers
  dim_t   cfg_width_r;
  dim_t   cfg_height_r;
  pad_t   cfg_pad_col_r;
  pad_t   cfg_pad_row_r;
  pitch_t cfg_pitch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r   <= DIM_W'(1);
      cfg_height_r  <= DIM_W'(1);
      cfg_pad_col_r <= '0;
      cfg_pad_row_r <= '0;
      cfg_pitch_r   <= PITCH_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  cfg_width_r   <= cfg_data[DIM_W-1:0];
        CFG_FRAME_HEIGHT: cfg_height_r  <= cfg_data[DIM_W-1:0];
        CFG_PAD_COLUMNS:  cfg_pad_col_r <= cfg_data[PAD_W-1:0];
        CFG_PAD_ROWS:     cfg_pad_row_r <= cfg_data[PAD_W-1:0];
        CFG_ROW_PITCH:    cfg_pitch_r   <= cfg_data[PITCH_W-1:0];
        default: ;
      endcase
    end
  end

  // effective frame geometry
  dim_t w_eff;
  dim_t h_eff;
  pad_t pc_eff;
  pad_t pr_eff;

  assign w_eff  = clamp_dim(cfg_width_r);
  assign h_eff  = clamp_dim(cfg_height_r);
  assign pc_eff = clamp_pad(cfg_pad_col_r);
  assign pr_eff = clamp_pad(cfg_pad_row_r);

  // sequencer and datapath registers
  state_t  state_r, state_nxt;
  pos_t    src_col_r, src_col_nxt;
  pos_t    src_row_r, src_row_nxt;
  span_t   rspan_r, rspan_nxt;
  span_t   cspan_r, cspan_nxt;
  crd_t    row_r, row_nxt;
  crd_t    col_r, col_nxt;
  cnt_t    cnt_r, cnt_nxt;
  addr_t   prod_r, prod_nxt;
  addr_t   rowstart_r, rowstart_nxt;
  addr_t   addr_r, addr_nxt;
  sample_t sample_r, sample_nxt;

  // position of the arriving sample, brought back into the frame
  logic  col_out;
  pos_t  col_fix;
  pos_t  row_adv;
  pos_t  row_fix;
  logic  [DIM_W-1:0] col_inc;
  logic  [DIM_W-1:0] row_inc;
  span_t rspan_w;
  span_t cspan_w;

  assign col_out = ({1'b0, src_col_r} >= w_eff);
  assign col_fix = col_out ? '0 : src_col_r;
  assign row_adv = col_out ? (src_row_r + POS_W'(1)) : src_row_r;
  assign row_fix = ({1'b0, row_adv} >= h_eff) ? '0 : row_adv;
  assign col_inc = {1'b0, col_fix} + DIM_W'(1);
  assign row_inc = {1'b0, row_fix} + DIM_W'(1);

  epad_axis u_row_axis (
    .pos  (row_fix),
    .size (h_eff),
    .pad  (pr_eff),
    .span (rspan_w)
  );

  epad_axis u_col_axis (
    .pos  (col_fix),
    .size (w_eff),
    .pad  (pc_eff),
    .span (cspan_w)
  );

  // row base multiply, one per sample
  logic [CRD_W+PITCH_W-1:0] prod_full;
  assign prod_full = rspan_r.first * cfg_pitch_r;

  // handshakes and end of the write sequence
  logic in_fire;
  logic out_fire;
  logic row_end;
  logic last_w;

  assign in_fire  = in_pix.valid && in_pix.ready;
  assign out_fire = out_wr.valid && out_wr.ready;
  assign row_end  = (col_r == cspan_r.last);
  assign last_w   = (row_end && (row_r == rspan_r.last))
                 || (cnt_r == CNT_W'(RESULT_LIMIT - 1));

  // next-state logic
  always_comb begin
    state_nxt    = state_r;
    src_col_nxt  = src_col_r;
    src_row_nxt  = src_row_r;
    rspan_nxt    = rspan_r;
    cspan_nxt    = cspan_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    cnt_nxt      = cnt_r;
    prod_nxt     = prod_r;
    rowstart_nxt = rowstart_r;
    addr_nxt     = addr_r;
    sample_nxt   = sample_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          sample_nxt = in_pix.pixel_value;
          rspan_nxt  = rspan_w;
          cspan_nxt  = cspan_w;
          row_nxt    = rspan_w.first;
          col_nxt    = cspan_w.first;
          cnt_nxt    = '0;
          // advance the frame position, wrapping after the last sample
          if (col_inc >= w_eff) begin
            src_col_nxt = '0;
            src_row_nxt = (row_inc >= h_eff) ? '0 : row_inc[POS_W-1:0];
          end else begin
            src_col_nxt = col_inc[POS_W-1:0];
            src_row_nxt = row_fix;
          end
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        prod_nxt  = prod_full[ADDR_W-1:0];
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        rowstart_nxt = prod_r + ADDR_W'(cspan_r.first);
        addr_nxt     = prod_r + ADDR_W'(cspan_r.first);
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        if (out_fire) begin
          cnt_nxt = cnt_r + CNT_W'(1);
          if (last_w) begin
            state_nxt = S_IDLE;
          end else if (row_end) begin
            row_nxt      = row_r + CRD_W'(1);
            col_nxt      = cspan_r.first;
            rowstart_nxt = rowstart_r + ADDR_W'(cfg_pitch_r);
            addr_nxt     = rowstart_r + ADDR_W'(cfg_pitch_r);
          end else begin
            col_nxt  = col_r + CRD_W'(1);
            addr_nxt = addr_r + ADDR_W'(1);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      src_col_r <= '0;
      src_row_r <= '0;
      cnt_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      src_col_r <= src_col_nxt;
      src_row_r <= src_row_nxt;
      cnt_r     <= cnt_nxt;
    end
    rspan_r    <= rspan_nxt;
    cspan_r    <= cspan_nxt;
    row_r      <= row_nxt;
    col_r      <= col_nxt;
    prod_r     <= prod_nxt;
    rowstart_r <= rowstart_nxt;
    addr_r     <= addr_nxt;
    sample_r   <= sample_nxt;
  end

  // channel outputs
  assign in_pix.ready        = (state_r == S_IDLE);
  assign out_wr.valid        = (state_r == S_EMIT);
  assign out_wr.dest_address = addr_r;
  assign out_wr.sample_out   = sample_r;
  assign out_wr.last_write   = last_w;

  // a sample is never taken while its writes are still going out
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_pix.ready |-> !out_wr.valid)
    else $error("input ready while writes pending");

  // the write limit always closes the sequence
  a_write_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_wr.valid && (cnt_r == CNT_W'(RESULT_LIMIT - 1))) |-> out_wr.last_write)
    else $error("write limit reached without last_write");

  // the final write frees the input on the next cycle
  a_release: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && out_wr.last_write) |=> in_pix.ready)
    else $error("input not ready after final write");

  // an accepted sample always yields at least one write after setup
  a_setup: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> ##3 (out_wr.valid && !in_pix.ready))
    else $error("setup did not reach the write phase");

endmodule

`default_nettype wire

// ----- bench/edge_replication_padder_test.sv -----
// Self-checking bench for edge_replication_padder: streams plane samples, predicts
// every padded buffer write in a local model and checks each one as it leaves.
// Depends on epad_pkg, epad_pix_if, epad_wr_if and the padder top level.

module edge_replication_padder_test;
  import epad_pkg::*;

  localparam int unsigned MAX_SIZE   = 4096;
  localparam int unsigned MAX_BORDER = 7;
  localparam int unsigned WRITE_CAP  = 64;
  localparam int unsigned LIMIT      = 600000;

  typedef struct {
    sample_t value;
    bit      hold;   // wait for all writes to drain before offering
  } pixel_item_t;

  typedef struct {
    addr_t   addr;
    sample_t sample;
    logic    last;
  } buffer_write_t;

  logic      clk;
  logic      rst_n;
  logic      cfg_we;
  cfg_idx_t  cfg_index;
  cfg_data_t cfg_data;

  epad_pix_if pix_ch ();
  epad_wr_if  wr_ch ();

  edge_replication_padder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_pix    (pix_ch),
    .out_wr    (wr_ch)
  );

  // model copy of the registers and the frame position
  dim_t        frame_w   = 1;
  dim_t        frame_h   = 1;
  pad_t        border_c  = 0;
  pad_t        border_r  = 0;
  pitch_t      frame_pitch = 1;
  int unsigned col_pos   = 0;
  int unsigned row_pos   = 0;

  pixel_item_t   pixel_queue[$];
  buffer_write_t write_queue[$];
  pixel_item_t   next_pixel;
  buffer_write_t due_write;

  int          sender_idle_pct   = 32;
  int          receiver_idle_pct = 72;
  int          error_count       = 0;
  int unsigned cycle_count       = 0;
  int          phase;
  int unsigned rand_w;
  int unsigned rand_h;
  int unsigned rand_pc;
  int unsigned rand_pr;
  int unsigned rand_pitch;
  int unsigned eff_w;

  // clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= 40) begin
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
    end
  endtask

  // destination positions along one axis, edges replicated outward
  function automatic void span_positions(input int unsigned pos, input int unsigned size,
                                         input int unsigned pad,
                                         output int unsigned lst[15],
                                         output int unsigned n);
    int unsigned k;
    n = 0;
    if (pos == 0) begin
      for (k = 0; k < pad; k++) begin
        lst[n] = k;
        n++;
      end
    end
    lst[n] = pos + pad;
    n++;
    if (pos == size - 1) begin
      for (k = 0; k < pad; k++) begin
        lst[n] = size + pad + k;
        n++;
      end
    end
  endfunction

  // expected buffer writes of one sample, then advance the frame position
  function automatic void predict_writes(input sample_t px);
    int unsigned      w;
    int unsigned      h;
    int unsigned      pc;
    int unsigned      pr;
    int unsigned      nr;
    int unsigned      nc;
    int unsigned      total;
    int unsigned      k;
    int unsigned      rlist[15];
    int unsigned      clist[15];
    longint unsigned  lin;
    buffer_write_t    bw;
    w  = (frame_w == 0) ? 1 : (frame_w > MAX_SIZE) ? MAX_SIZE : frame_w;
    h  = (frame_h == 0) ? 1 : (frame_h > MAX_SIZE) ? MAX_SIZE : frame_h;
    pc = (border_c > MAX_BORDER) ? MAX_BORDER : border_c;
    pr = (border_r > MAX_BORDER) ? MAX_BORDER : border_r;

    // position left outside the frame by a register change
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) begin
      row_pos = 0;
    end

    span_positions(row_pos, h, pr, rlist, nr);
    span_positions(col_pos, w, pc, clist, nc);
    total = nr * nc;
    if (total > WRITE_CAP) begin
      total = WRITE_CAP;
    end
    for (k = 0; k < total; k++) begin
      lin = longint'(rlist[k / nc]) * longint'(frame_pitch) + longint'(clist[k % nc]);
      bw.addr   = addr_t'(lin);
      bw.sample = px;
      bw.last   = (k == total - 1);
      write_queue.push_back(bw);
    end

    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) begin
        row_pos = 0;
      end
    end
  endfunction

  // sample driver: offers queued items, predicts on each accepted one
  always @(posedge clk) begin
    if (!rst_n) begin
      pix_ch.valid       <= 1'b0;
      pix_ch.pixel_value <= '0;
    end else begin
      if (pix_ch.valid && pix_ch.ready) begin
        predict_writes(pix_ch.pixel_value);
      end
      if (!pix_ch.valid || pix_ch.ready) begin
        if (pixel_queue.size() > 0 &&
            !(pixel_queue[0].hold && write_queue.size() > 0) &&
            $urandom_range(0, 99) >= sender_idle_pct) begin
          next_pixel = pixel_queue.pop_front();
          pix_ch.valid       <= 1'b1;
          pix_ch.pixel_value <= next_pixel.value;
        end else begin
          pix_ch.valid <= 1'b0;
        end
      end
    end
  end

  // write monitor: random back-pressure, checks each accepted write
  always @(posedge clk) begin
    if (!rst_n) begin
      wr_ch.ready <= 1'b0;
    end else begin
      if (wr_ch.valid && wr_ch.ready) begin
        if (write_queue.size() == 0) begin
          report_mismatch($sformatf("unexpected write addr %0h sample %0h",
                                    wr_ch.dest_address, wr_ch.sample_out));
        end else begin
          due_write = write_queue.pop_front();
          if (wr_ch.dest_address !== due_write.addr) begin
            report_mismatch($sformatf("dest_address %0h, expected %0h",
                                      wr_ch.dest_address, due_write.addr));
          end
          if (wr_ch.sample_out !== due_write.sample) begin
            report_mismatch($sformatf("sample_out %0h, expected %0h",
                                      wr_ch.sample_out, due_write.sample));
          end
          if (wr_ch.last_write !== due_write.last) begin
            report_mismatch($sformatf("last_write %0b, expected %0b at addr %0h",
                                      wr_ch.last_write, due_write.last, due_write.addr));
          end
        end
      end
      wr_ch.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end
  end

  // one register write, mirrored into the model
  task automatic write_reg(input cfg_reg_t idx, input int unsigned val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= cfg_data_t'(val);
    case (idx)
      CFG_FRAME_WIDTH:  frame_w     = dim_t'(val);
      CFG_FRAME_HEIGHT: frame_h     = dim_t'(val);
      CFG_PAD_COLUMNS:  border_c    = pad_t'(val);
      CFG_PAD_ROWS:     border_r    = pad_t'(val);
      CFG_ROW_PITCH:    frame_pitch = pitch_t'(val);
      default: ;
    endcase
  endtask

  task automatic load_geometry(input int unsigned w, input int unsigned h,
                               input int unsigned pc, input int unsigned pr,
                               input int unsigned pitch);
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
    write_reg(CFG_PAD_COLUMNS, pc);
    write_reg(CFG_PAD_ROWS, pr);
    write_reg(CFG_ROW_PITCH, pitch);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_pixel(input sample_t value, input bit hold);
    pixel_item_t item;
    item.value = value;
    item.hold  = hold;
    pixel_queue.push_back(item);
  endtask

  task automatic queue_pixels(input int n, input int hold_at);
    for (int i = 0; i < n; i++) begin
      push_pixel(sample_t'($urandom), i == hold_at);
    end
  endtask

  // all items taken and every predicted write seen
  task automatic drain_writes(input int settle);
    while (pixel_queue.size() != 0 || pix_ch.valid || write_queue.size() != 0) begin
      @(negedge clk);
    end
    repeat (settle) @(negedge clk);
  endtask

  function automatic int unsigned random_dim();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return $urandom_range(4097, 8191);
      2:       return 4096;
      default: return $urandom_range(1, 6);
    endcase
  endfunction

  // stimulus and end of run
  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = CFG_FRAME_WIDTH;
    cfg_data           = '0;
    pix_ch.valid       = 1'b0;
    pix_ch.pixel_value = '0;
    wr_ch.ready        = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // zero size with full pads: corner blocks overflow the write cap
    load_geometry(0, 0, 7, 7, 16383);
    push_pixel(16'h0000, 1'b1);
    push_pixel(16'hFFFF, 1'b0);
    push_pixel(16'hAAAA, 1'b0);
    push_pixel(16'h5555, 1'b0);
    drain_writes(3);

    // small frame, one full pass plus a wrap into the next frame
    load_geometry(3, 2, 2, 1, 9);
    queue_pixels(8, -1);
    drain_writes(3);

    // width shrinks under the column counter
    load_geometry(1, 2, 2, 1, 5);
    queue_pixels(2, -1);
    drain_writes(3);

    // oversize plane with zero pitch
    load_geometry(8191, 4097, 0, 0, 0);
    queue_pixels(3, -1);
    drain_writes(3);

    // one-column plane, pitch below the padded width
    load_geometry(1, 3, 7, 0, 3);
    queue_pixels(3, 1);
    drain_writes(3);

    // random geometries across the three idling patterns
    for (phase = 0; phase < 12; phase++) begin
      if (phase < 4) begin
        sender_idle_pct   = 32;
        receiver_idle_pct = 72;
      end else if (phase < 8) begin
        sender_idle_pct   = 72;
        receiver_idle_pct = 32;
      end else begin
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
      end
      rand_w  = random_dim();
      rand_h  = random_dim();
      rand_pc = $urandom_range(0, 7);
      rand_pr = $urandom_range(0, 7);
      eff_w   = (rand_w == 0) ? 1 : (rand_w > MAX_SIZE) ? MAX_SIZE : rand_w;
      case ($urandom_range(0, 5))
        0:       rand_pitch = $urandom_range(0, 16383);
        1:       rand_pitch = 16383;
        2:       rand_pitch = 0;
        default: rand_pitch = eff_w + 2 * rand_pc + $urandom_range(0, 4);
      endcase
      load_geometry(rand_w, rand_h, rand_pc, rand_pr, rand_pitch);
      queue_pixels(27, (phase % 3 == 0) ? 13 : -1);
      drain_writes(3);
    end

    // tall one-column plane: top pad rows at the widest pitch
    load_geometry(1, 4096, 0, 7, 16383);
    queue_pixels(4, -1);
    drain_writes(70);

    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
